// ----- hdl/tla_pkg.sv -----
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants of the toroidal life automaton.
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RUN   = 2'd3;

  localparam logic       REG_GRID_SIDE = 1'b0;
  localparam logic       REG_GEN_COUNT = 1'b1;

  localparam logic       RESP_READ = 1'b0;
  localparam logic       RESP_DONE = 1'b1;

  localparam int unsigned SIDE_W  = 8;
  localparam int unsigned GEN_W   = 16;
  localparam int unsigned CELL_W  = 7;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned SIDE_MIN = 3;
  localparam int unsigned SIDE_RST = 100;
  localparam int unsigned GEN_RST  = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DO,
    ST_PRE_A,
    ST_PRE_B,
    ST_PRE_C,
    ST_ROW_RD,
    ST_ROW_CALC,
    ST_GEN_END,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_CELL,
    RA_LAST,
    RA_ZERO,
    RA_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch_req;
    logic    clr_all;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cell_wr;
    logic    load_prev;
    logic    load_cur;
    logic    row_calc;
    logic    gen_clr;
    logic    gen_inc;
    logic    out_read;
    logic    out_done;
  } cmd_t;

  typedef struct packed {
    logic       req_write;
    logic       row_last;
    logic       gen_last;
    logic       gen_zero;
    logic       changed;
    logic       out_free;
  } sts_t;

endpackage

// ----- hdl/tla_if.sv -----
// ----------------------------------------------------------------------------
// tla_in_if / tla_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] cell_row;
  logic [6:0] cell_column;
  logic       write_alive;

  modport source (output valid, req_type, cell_row, cell_column, write_alive,
                  input ready);
  modport sink   (input valid, req_type, cell_row, cell_column, write_alive,
                  output ready);
endinterface

interface tla_out_if;
  logic        valid;
  logic        ready;
  logic        resp_kind;
  logic        read_alive;
  logic [15:0] generations_done;

  modport source (output valid, resp_kind, read_alive, generations_done,
                  input ready);
  modport sink   (input valid, resp_kind, read_alive, generations_done,
                  output ready);
endinterface

// ----- hdl/tla_ctrl.sv -----
// ----------------------------------------------------------------------------
// tla_ctrl
// Sequencer for requests and the row sweep of each generation.
// ----------------------------------------------------------------------------
module tla_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_req_type,
  output logic           in_ready,
  input  tla_pkg::sts_t  sts,
  output tla_pkg::cmd_t  cmd
);

  tla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tla_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tla_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            tla_pkg::REQ_WRITE: state_nxt = tla_pkg::ST_CELL_RD;
            tla_pkg::REQ_READ:  state_nxt = tla_pkg::ST_CELL_RD;
            tla_pkg::REQ_RUN:   state_nxt = sts.gen_zero ? tla_pkg::ST_DONE
                                                         : tla_pkg::ST_PRE_A;
            default:            state_nxt = tla_pkg::ST_IDLE;
          endcase
        end
      end
      tla_pkg::ST_CELL_RD: state_nxt = tla_pkg::ST_CELL_DO;
      tla_pkg::ST_CELL_DO: begin
        if (sts.req_write || sts.out_free) begin
          state_nxt = tla_pkg::ST_IDLE;
        end
      end
      tla_pkg::ST_PRE_A: state_nxt = tla_pkg::ST_PRE_B;
      tla_pkg::ST_PRE_B: state_nxt = tla_pkg::ST_PRE_C;
      tla_pkg::ST_PRE_C: state_nxt = tla_pkg::ST_ROW_RD;
      tla_pkg::ST_ROW_RD: state_nxt = tla_pkg::ST_ROW_CALC;
      tla_pkg::ST_ROW_CALC: begin
        state_nxt = sts.row_last ? tla_pkg::ST_GEN_END : tla_pkg::ST_ROW_RD;
      end
      tla_pkg::ST_GEN_END: begin
        state_nxt = (sts.gen_last || !sts.changed) ? tla_pkg::ST_DONE
                                                   : tla_pkg::ST_PRE_A;
      end
      tla_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = tla_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = tla_pkg::RA_CELL;
    in_ready = 1'b0;
    case (state_r)
      tla_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
        cmd.clr_all   = in_valid && (in_req_type == tla_pkg::REQ_CLEAR);
        cmd.gen_clr   = in_valid;
      end
      tla_pkg::ST_CELL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tla_pkg::RA_CELL;
      end
      tla_pkg::ST_CELL_DO: begin
        cmd.cell_wr  = sts.req_write;
        cmd.out_read = !sts.req_write && sts.out_free;
      end
      tla_pkg::ST_PRE_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tla_pkg::RA_LAST;
      end
      tla_pkg::ST_PRE_B: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = tla_pkg::RA_ZERO;
        cmd.load_prev = 1'b1;
      end
      tla_pkg::ST_PRE_C: begin
        cmd.load_cur = 1'b1;
      end
      tla_pkg::ST_ROW_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tla_pkg::RA_NEXT;
      end
      tla_pkg::ST_ROW_CALC: begin
        cmd.row_calc = 1'b1;
      end
      tla_pkg::ST_GEN_END: begin
        cmd.gen_inc = 1'b1;
      end
      tla_pkg::ST_DONE: begin
        cmd.out_done = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/tla_dp.sv -----
// ----------------------------------------------------------------------------
// tla_dp
// Grid row memory, row window, next-row logic, counters and result register.
// ----------------------------------------------------------------------------
module tla_dp #(
  parameter int unsigned GRID_MAX = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tla_pkg::cmd_t                cmd,
  output tla_pkg::sts_t                sts,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                   in_req_type,
  input  logic [tla_pkg::CELL_W-1:0]   in_cell_row,
  input  logic [tla_pkg::CELL_W-1:0]   in_cell_column,
  input  logic                         in_write_alive,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_resp_kind,
  output logic                         out_read_alive,
  output logic [tla_pkg::GEN_W-1:0]    out_generations_done
);

  localparam int unsigned RW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int unsigned CW = $clog2(GRID_MAX + 1);
  localparam int unsigned SW = (CW > tla_pkg::SIDE_W) ? CW : tla_pkg::SIDE_W;

  logic [GRID_MAX-1:0] mem [GRID_MAX];
  logic [GRID_MAX-1:0] vld_r;
  logic [GRID_MAX-1:0] rd_q_r;
  logic                rd_vld_r;
  logic [GRID_MAX-1:0] rdata;

  logic [tla_pkg::SIDE_W-1:0] side_r;
  logic [tla_pkg::GEN_W-1:0]  gcnt_r;

  logic                req_write_r;
  logic                in_range_r;
  logic [RW-1:0]       row_q_r;
  logic [RW-1:0]       col_q_r;
  logic                alive_q_r;

  logic [GRID_MAX-1:0] prev_r, cur_r, row0_r;
  logic [RW-1:0]       r_r;
  logic                changed_r;
  logic [tla_pkg::GEN_W-1:0] gen_r;

  logic                out_valid_r, out_kind_r, out_alive_r;
  logic [tla_pkg::GEN_W-1:0] out_gen_r;

  logic [SW-1:0]       side_sw;
  logic [SW-1:0]       n_sw;
  logic [CW-1:0]       n;
  logic [RW-1:0]       nm1;
  logic                row_last;
  logic [RW-1:0]       rd_addr;
  logic                wr_en;
  logic [RW-1:0]       wr_addr;
  logic [GRID_MAX-1:0] wr_data;
  logic [GRID_MAX-1:0] nxt_row;
  logic [GRID_MAX-1:0] new_row;
  logic                in_range;

  assign side_sw = SW'(side_r);
  always_comb begin
    if (side_sw < SW'(tla_pkg::SIDE_MIN)) begin
      n_sw = SW'(tla_pkg::SIDE_MIN);
    end else if (side_sw > SW'(GRID_MAX)) begin
      n_sw = SW'(GRID_MAX);
    end else begin
      n_sw = side_sw;
    end
  end
  assign n        = n_sw[CW-1:0];
  assign nm1      = RW'(n - CW'(1));
  assign row_last = (r_r == nm1);
  assign in_range = (SW'(in_cell_row) < n_sw) && (SW'(in_cell_column) < n_sw);
  assign rdata    = rd_vld_r ? rd_q_r : '0;
  assign nxt_row  = row_last ? row0_r : rdata;

  always_comb begin
    case (cmd.rd_sel)
      tla_pkg::RA_CELL: rd_addr = row_q_r;
      tla_pkg::RA_LAST: rd_addr = nm1;
      tla_pkg::RA_ZERO: rd_addr = '0;
      tla_pkg::RA_NEXT: rd_addr = RW'(r_r + RW'(1));
      default:          rd_addr = '0;
    endcase
  end

  always_comb begin
    logic [3:0] cnt;
    logic       pl, pr, cl, cr, nl, nr;
    new_row = cur_r;
    for (int c = 0; c < GRID_MAX; c++) begin
      if (c == 0) begin
        pl = prev_r[nm1]; cl = cur_r[nm1]; nl = nxt_row[nm1];
      end else begin
        pl = prev_r[(c + GRID_MAX - 1) % GRID_MAX];
        cl = cur_r[(c + GRID_MAX - 1) % GRID_MAX];
        nl = nxt_row[(c + GRID_MAX - 1) % GRID_MAX];
      end
      if (RW'(c) == nm1) begin
        pr = prev_r[0]; cr = cur_r[0]; nr = nxt_row[0];
      end else begin
        pr = prev_r[(c + 1) % GRID_MAX];
        cr = cur_r[(c + 1) % GRID_MAX];
        nr = nxt_row[(c + 1) % GRID_MAX];
      end
      cnt = 4'(pl) + 4'(prev_r[c]) + 4'(pr) + 4'(cl) + 4'(cr)
          + 4'(nl) + 4'(nxt_row[c]) + 4'(nr);
      if (CW'(c) < n) begin
        if (cnt == 4'd3) begin
          new_row[c] = 1'b1;
        end else if (cnt == 4'd2) begin
          new_row[c] = cur_r[c];
        end else begin
          new_row[c] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = r_r;
    wr_data = new_row;
    if (cmd.cell_wr) begin
      wr_en   = in_range_r;
      wr_addr = row_q_r;
      wr_data = rdata;
      wr_data[col_q_r] = alive_q_r;
    end else if (cmd.row_calc) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= tla_pkg::SIDE_W'(tla_pkg::SIDE_RST);
      gcnt_r <= tla_pkg::GEN_W'(tla_pkg::GEN_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        tla_pkg::REG_GRID_SIDE: side_r <= cfg_data[tla_pkg::SIDE_W-1:0];
        tla_pkg::REG_GEN_COUNT: gcnt_r <= cfg_data[tla_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_write_r <= (in_req_type == tla_pkg::REQ_WRITE);
      in_range_r  <= in_range;
      row_q_r     <= RW'(in_cell_row);
      col_q_r     <= RW'(in_cell_column);
      alive_q_r   <= in_write_alive;
    end
    if (cmd.load_prev) begin
      prev_r <= rdata;
    end
    if (cmd.load_cur) begin
      cur_r  <= rdata;
      row0_r <= rdata;
    end
    if (cmd.row_calc) begin
      prev_r <= cur_r;
      cur_r  <= nxt_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r       <= '0;
      changed_r <= 1'b0;
      gen_r     <= '0;
    end else begin
      if (cmd.load_prev) begin
        r_r       <= '0;
        changed_r <= 1'b0;
      end else if (cmd.row_calc) begin
        r_r       <= RW'(r_r + RW'(1));
        changed_r <= changed_r | (|(new_row ^ cur_r));
      end
      if (cmd.gen_clr) begin
        gen_r <= '0;
      end else if (cmd.gen_inc) begin
        gen_r <= gen_r + tla_pkg::GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_read || cmd.out_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      out_kind_r  <= tla_pkg::RESP_READ;
      out_alive_r <= in_range_r & rdata[col_q_r];
      out_gen_r   <= '0;
    end else if (cmd.out_done) begin
      out_kind_r  <= tla_pkg::RESP_DONE;
      out_alive_r <= 1'b0;
      out_gen_r   <= gcnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_resp_kind        = out_kind_r;
  assign out_read_alive       = out_alive_r;
  assign out_generations_done = out_gen_r;

  assign sts.req_write = req_write_r;
  assign sts.row_last  = row_last;
  assign sts.gen_last  = ((gen_r + tla_pkg::GEN_W'(1)) == gcnt_r);
  assign sts.gen_zero  = (gcnt_r == '0);
  assign sts.changed   = changed_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ----- hdl/toroidal_life_automaton_top.sv -----
// ----------------------------------------------------------------------------
// toroidal_life_automaton_top
// Conway life (B3/S23) on a wrapping square grid with cell access and runs.
// ----------------------------------------------------------------------------
// The grid is stored as GRID_MAX rows of GRID_MAX bits in one memory with a
// registered read port; a per-row valid bit lets reset and clear mark every
// row dead without writing the memory. A run sweeps the rows through a
// three-row window: each generation reads the last row and row zero, then
// reads and computes each row in turn, paced by the single memory read
// port. A run stops early once a generation changes nothing.
module toroidal_life_automaton_top #(
  parameter int unsigned GRID_MAX = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [tla_pkg::CFG_W-1:0] cfg_data,
  tla_in_if.sink                    in_ch,
  tla_out_if.source                 out_ch
);

  tla_pkg::cmd_t cmd;
  tla_pkg::sts_t sts;

  tla_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tla_dp #(
    .GRID_MAX (GRID_MAX)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_req_type          (in_ch.req_type),
    .in_cell_row          (in_ch.cell_row),
    .in_cell_column       (in_ch.cell_column),
    .in_write_alive       (in_ch.write_alive),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_resp_kind        (out_ch.resp_kind),
    .out_read_alive       (out_ch.read_alive),
    .out_generations_done (out_ch.generations_done)
  );

endmodule

// ----- tb/toroidal_life_automaton_top_test.sv -----
// ----------------------------------------------------------------------------
// toroidal_life_automaton_top_test
// Drives clear, write, read and run requests into the life automaton, keeps
// a shadow grid that evolves by the B3/S23 wrap rule, and checks every read
// and run result in order. Grid side and generation count are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module toroidal_life_automaton_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GMAX = 128;

  typedef struct packed {
    logic        kind;
    logic        alive;
    logic [15:0] gens;
  } resp_t;

  typedef struct packed {
    logic [1:0] req;
    logic [6:0] row;
    logic [6:0] col;
    logic       alive;
    logic       has_exp;
    resp_t      exp;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = tla_pkg::REG_GRID_SIDE;
  logic [tla_pkg::CFG_W-1:0] cfg_data = '0;

  tla_in_if  in_ch ();
  tla_out_if out_ch ();

  toroidal_life_automaton_top #(.GRID_MAX(GMAX)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  bit          life [GMAX][GMAX];
  bit          life_nxt [GMAX][GMAX];
  logic [7:0]  side_reg;
  logic [15:0] gen_reg;
  resp_t       pending_resps[$];
  int          errors = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2s;
    $display("toroidal_life_automaton_top_test NOT OK");
    $finish;
  end

  function automatic int unsigned eff_side();
    if (side_reg < tla_pkg::SIDE_MIN) return tla_pkg::SIDE_MIN;
    if (side_reg > GMAX) return GMAX;
    return 32'(side_reg);
  endfunction

  function automatic bit evolve_once(int unsigned n);
    int unsigned cnt;
    bit chg;
    chg = 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
              cnt += 32'(life[(r + n + dr) % n][(c + n + dc) % n]);
        life_nxt[r][c] = (cnt == 3) ? 1'b1 : (cnt == 2) ? life[r][c] : 1'b0;
      end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (life[r][c] != life_nxt[r][c]) chg = 1;
        life[r][c] = life_nxt[r][c];
      end
    return chg;
  endfunction

  // Updates the shadow grid; returns 1 with the result when one is due.
  function automatic bit predict_life(stim_t s, output resp_t r);
    int unsigned n;
    n = eff_side();
    r = '0;
    case (s.req)
      tla_pkg::REQ_CLEAR: begin
        foreach (life[i, j]) life[i][j] = 0;
        return 0;
      end
      tla_pkg::REQ_WRITE: begin
        if (s.row < n && s.col < n) life[s.row][s.col] = s.alive;
        return 0;
      end
      tla_pkg::REQ_READ: begin
        r.kind = tla_pkg::RESP_READ;
        r.alive = (s.row < n && s.col < n) ? life[s.row][s.col] : 1'b0;
        return 1;
      end
      default: begin
        for (int g = 0; g < gen_reg; g++)
          if (!evolve_once(n)) break;
        r.kind = tla_pkg::RESP_DONE;
        r.gens = gen_reg;
        return 1;
      end
    endcase
  endfunction

  task automatic write_reg(logic idx, logic [tla_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tla_pkg::REG_GRID_SIDE) side_reg = val[7:0];
    else gen_reg = val;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  int burst_left = 0;

  task automatic send_item(stim_t s);
    resp_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= s.req;
    in_ch.cell_row <= s.row;
    in_ch.cell_column <= s.col;
    in_ch.write_alive <= s.alive;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_life(s, r)) begin
      if (s.has_exp && r != s.exp) begin
        $error("directed row: expected %h predicted %h", s.exp, r);
        errors++;
      end
      pending_resps.push_back(r);
    end
  endtask

  function automatic stim_t mk(logic [1:0] q, int rw, int cl, bit a);
    stim_t s;
    s = '0;
    s.req = q; s.row = 7'(rw); s.col = 7'(cl); s.alive = a;
    return s;
  endfunction

  function automatic stim_t rand_item(int unsigned n);
    stim_t s;
    int unsigned lim;
    s = '0;
    lim = ($urandom_range(0, 9) == 0) ? 127 : n - 1;
    case ($urandom_range(0, 99)) inside
      [0:1]:   s.req = tla_pkg::REQ_CLEAR;
      [2:59]:  s.req = tla_pkg::REQ_WRITE;
      [60:93]: s.req = tla_pkg::REQ_READ;
      default: s.req = tla_pkg::REQ_RUN;
    endcase
    s.row = 7'($urandom_range(0, lim));
    s.col = 7'($urandom_range(0, lim));
    s.alive = ($urandom_range(0, 2) != 0);
    return s;
  endfunction

  // Result side: stall pattern and in-order compare.
  initial begin
    resp_t e;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_resps.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          e = pending_resps.pop_front();
          if (out_ch.resp_kind !== e.kind) begin
            $error("resp_kind exp %0d got %0d", e.kind, out_ch.resp_kind);
            errors++;
          end
          if (out_ch.read_alive !== e.alive) begin
            $error("read_alive exp %0d got %0d", e.alive, out_ch.read_alive);
            errors++;
          end
          if (out_ch.generations_done !== e.gens) begin
            $error("generations_done exp %0d got %0d", e.gens,
                   out_ch.generations_done);
            errors++;
          end
        end
      end
      out_ch.ready <= (($urandom_range(0, 15) < 11) || (($urandom >> 3) % 5 == 0));
    end
  end

  stim_t directed[$];

  initial begin
    int unsigned n;
    in_ch.valid = 1'b0;
    in_ch.req_type = tla_pkg::REQ_CLEAR;
    in_ch.cell_row = '0;
    in_ch.cell_column = '0;
    in_ch.write_alive = 1'b0;
    side_reg = 8'(tla_pkg::SIDE_RST);
    gen_reg = 16'(tla_pkg::GEN_RST);
    foreach (life[i, j]) life[i][j] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // after reset: dead, extremes, outside reads, blinker
    directed.push_back(mk(tla_pkg::REQ_READ, 0, 0, 0));
    directed[$].has_exp = 1;
    directed.push_back(mk(tla_pkg::REQ_WRITE, 99, 99, 1));
    directed.push_back(mk(tla_pkg::REQ_READ, 99, 99, 0));
    directed[$].has_exp = 1;
    directed[$].exp = '{tla_pkg::RESP_READ, 1'b1, 16'd0};
    directed.push_back(mk(tla_pkg::REQ_WRITE, 127, 127, 1));
    directed.push_back(mk(tla_pkg::REQ_READ, 127, 127, 0));
    directed[$].has_exp = 1;
    directed.push_back(mk(tla_pkg::REQ_READ, 100, 0, 0));
    directed[$].has_exp = 1;
    directed.push_back(mk(tla_pkg::REQ_WRITE, 99, 99, 0));
    directed.push_back(mk(tla_pkg::REQ_WRITE, 0, 0, 1));
    directed.push_back(mk(tla_pkg::REQ_WRITE, 0, 1, 1));
    directed.push_back(mk(tla_pkg::REQ_WRITE, 0, 99, 1));
    directed.push_back(mk(tla_pkg::REQ_RUN, 0, 0, 0));
    directed[$].has_exp = 1;
    directed[$].exp = '{tla_pkg::RESP_DONE, 1'b0, 16'd4};
    directed.push_back(mk(tla_pkg::REQ_READ, 0, 0, 0));
    directed.push_back(mk(tla_pkg::REQ_READ, 1, 0, 0));
    directed.push_back(mk(tla_pkg::REQ_READ, 99, 0, 0));
    directed.push_back(mk(tla_pkg::REQ_CLEAR, 0, 0, 0));
    directed.push_back(mk(tla_pkg::REQ_READ, 0, 0, 0));
    directed[$].has_exp = 1;
    foreach (directed[i]) send_item(directed[i]);
    wait_idle();

    // odd generation count on side 3 (wrap in both directions)
    write_reg(tla_pkg::REG_GRID_SIDE, '0);
    write_reg(tla_pkg::REG_GEN_COUNT, tla_pkg::CFG_W'(1));
    directed = {};
    directed.push_back(mk(tla_pkg::REQ_WRITE, 2, 2, 1));
    directed.push_back(mk(tla_pkg::REQ_WRITE, 0, 2, 1));
    directed.push_back(mk(tla_pkg::REQ_WRITE, 2, 0, 1));
    directed.push_back(mk(tla_pkg::REQ_RUN, 0, 0, 0));
    directed.push_back(mk(tla_pkg::REQ_READ, 1, 1, 0));
    directed.push_back(mk(tla_pkg::REQ_READ, 3, 3, 0));
    directed[$].has_exp = 1;
    foreach (directed[i]) send_item(directed[i]);
    wait_idle();
    write_reg(tla_pkg::REG_GEN_COUNT, '0);
    send_item(mk(tla_pkg::REQ_RUN, 0, 0, 0));
    wait_idle();

    // random phases over several sides and counts
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 8)
        0: write_reg(tla_pkg::REG_GRID_SIDE, tla_pkg::CFG_W'(3));
        1: write_reg(tla_pkg::REG_GRID_SIDE, tla_pkg::CFG_W'(255));
        2: write_reg(tla_pkg::REG_GRID_SIDE, tla_pkg::CFG_W'(128));
        default: write_reg(tla_pkg::REG_GRID_SIDE,
                           tla_pkg::CFG_W'($urandom_range(3, 12)));
      endcase
      if (ph == 5) write_reg(tla_pkg::REG_GEN_COUNT, 16'hFFFF);
      else write_reg(tla_pkg::REG_GEN_COUNT, tla_pkg::CFG_W'($urandom_range(1, 6)));
      n = eff_side();
      for (int k = 0; k < 125; k++) begin
        if (n > 20 && k % 40 == 39) send_item(mk(tla_pkg::REQ_RUN, 0, 0, 0));
        else if (n > 20) begin
          stim_t s;
          s = rand_item(n);
          if (s.req == tla_pkg::REQ_RUN) s.req = tla_pkg::REQ_READ;
          if ($urandom_range(0, 1) == 0 && s.req == tla_pkg::REQ_WRITE) begin
            s.row = 7'($urandom_range(0, 9)); s.col = 7'($urandom_range(0, 9));
          end
          send_item(s);
        end else send_item(rand_item(n));
        if (k == 60) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_resps.size() != 0) @(posedge clk);
        end
      end
      if (ph == 5) begin
        send_item(mk(tla_pkg::REQ_CLEAR, 0, 0, 0));
        send_item(mk(tla_pkg::REQ_RUN, 0, 0, 0));
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending_resps.size() == 0)
      $display("toroidal_life_automaton_top_test OK");
    else
      $display("toroidal_life_automaton_top_test NOT OK");
    $finish;
  end
endmodule
